[hw/rtl/grs_pkg.sv]
// ----------------------------------------------------------------------------
// grs_pkg
// Shared constants, codes and types for the grid relaxation sweep block.
// ----------------------------------------------------------------------------
`default_nettype none

package grs_pkg;

  // tile geometry and cell format
  localparam int MAX_SIDE   = 64;
  localparam int VALUE_BITS = 32;

  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int TILE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int TILE_AW    = 2 * SIDE_W;
  localparam int HALO_DEPTH = 4 * MAX_SIDE;
  localparam int HALO_AW    = SIDE_W + 2;
  localparam int SUM_W      = VALUE_BITS + 2;

  // fixed port widths
  localparam int CMD_W   = 2;
  localparam int HSIDE_W = 2;
  localparam int COORD_W = 6;
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 7;

  localparam logic [CFG_W-1:0] SIDE_MIN   = CFG_W'(2);
  localparam logic [CFG_W-1:0] SIDE_MAX   = CFG_W'(MAX_SIDE);
  localparam logic [CFG_W-1:0] SIDE_RESET = CFG_W'(64);

  typedef logic [VALUE_BITS-1:0] cell_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_CELL = 2'd0,
    CMD_WRITE_HALO = 2'd1,
    CMD_SWEEP      = 2'd2,
    CMD_READ_CELL  = 2'd3
  } cmd_e;

  typedef enum logic [HSIDE_W-1:0] {
    HALO_UP    = 2'd0,
    HALO_DOWN  = 2'd1,
    HALO_LEFT  = 2'd2,
    HALO_RIGHT = 2'd3
  } halo_e;

  // kind of cell being relaxed, in sweep order
  typedef enum logic [3:0] {
    VIS_TL    = 4'd0,
    VIS_TR    = 4'd1,
    VIS_BL    = 4'd2,
    VIS_BR    = 4'd3,
    VIS_TOP   = 4'd4,
    VIS_BOT   = 4'd5,
    VIS_LEFT  = 4'd6,
    VIS_RIGHT = 4'd7,
    VIS_INNER = 4'd8
  } visit_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_READ   = 3'd1,
    ST_SW_RD0 = 3'd2,
    ST_SW_RD1 = 3'd3,
    ST_SW_WR  = 3'd4
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic              wr_cell;
    logic              wr_halo;
    logic              rd_cell;
    logic              rd_capture;
    logic              rd_zero;
    logic              sw_rd1;
    logic              sw_wr;
    visit_e            kind;
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
  } ctl_t;

  // input word sign-extended, then wrapped to the cell width
  function automatic cell_t wrap_in(input logic [DATA_W-1:0] v);
    logic [2*DATA_W-1:0] ext;
    ext = {{DATA_W{v[DATA_W-1]}}, v};
    return ext[VALUE_BITS-1:0];
  endfunction

  // low output bits of the sign-extended cell
  function automatic logic [DATA_W-1:0] cell_out(input cell_t c);
    logic [VALUE_BITS+DATA_W-1:0] ext;
    ext = {{DATA_W{c[VALUE_BITS-1]}}, c};
    return ext[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/grs_ram.sv]
// ----------------------------------------------------------------------------
// grs_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module grs_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

[hw/rtl/grs_ctrl.sv]
// ----------------------------------------------------------------------------
// grs_ctrl
// Controller: command decode, grid side register and the sweep cell walker.
// ----------------------------------------------------------------------------
`default_nettype none

module grs_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [grs_pkg::CMD_W-1:0]     command_i,
  input  wire logic [grs_pkg::COORD_W-1:0]   row_i,
  input  wire logic [grs_pkg::COORD_W-1:0]   col_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [grs_pkg::CFG_W-1:0]     cfg_grid_side_i,
  output logic                               cfg_ready_o,
  output logic                               busy_o,
  output grs_pkg::ctl_t                      ctl_o
);

  import grs_pkg::*;

  state_e            state_q, state_d;
  visit_e            kind_q, kind_d;
  logic [SIDE_W-1:0] i_q, i_d;
  logic [SIDE_W-1:0] j_q, j_d;
  logic              rd_zero_q, rd_zero_d;
  logic [CFG_W-1:0]  side_q;

  logic [CFG_W-1:0]  side_n;
  logic [CFG_W-1:0]  last_full;
  logic [SIDE_W-1:0] last;
  logic [SIDE_W-1:0] last_m1;
  logic              in_range;
  logic [SIDE_W-1:0] tgt_row;
  logic [SIDE_W-1:0] tgt_col;
  cmd_e              cmd;

  assign cmd = cmd_e'(command_i);

  // clamp the side in use
  always_comb begin
    if (side_q < SIDE_MIN) begin
      side_n = SIDE_MIN;
    end else if (side_q > SIDE_MAX) begin
      side_n = SIDE_MAX;
    end else begin
      side_n = side_q;
    end
  end

  assign last_full = side_n - CFG_W'(1);
  assign last      = last_full[SIDE_W-1:0];
  assign last_m1   = last - SIDE_W'(1);
  assign in_range  = (CFG_W'(row_i) < side_n) && (CFG_W'(col_i) < side_n);

  // target cell of the current visit
  always_comb begin
    case (kind_q)
      VIS_TL:    begin tgt_row = '0;   tgt_col = '0;   end
      VIS_TR:    begin tgt_row = '0;   tgt_col = last; end
      VIS_BL:    begin tgt_row = last; tgt_col = '0;   end
      VIS_BR:    begin tgt_row = last; tgt_col = last; end
      VIS_TOP:   begin tgt_row = '0;   tgt_col = i_q;  end
      VIS_BOT:   begin tgt_row = last; tgt_col = i_q;  end
      VIS_LEFT:  begin tgt_row = i_q;  tgt_col = '0;   end
      VIS_RIGHT: begin tgt_row = i_q;  tgt_col = last; end
      VIS_INNER: begin tgt_row = i_q;  tgt_col = j_q;  end
      default:   begin tgt_row = '0;   tgt_col = '0;   end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      kind_q    <= VIS_TL;
      i_q       <= '0;
      j_q       <= '0;
      rd_zero_q <= 1'b0;
      side_q    <= SIDE_RESET;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      i_q       <= i_d;
      j_q       <= j_d;
      rd_zero_q <= rd_zero_d;
      if (cfg_valid_i) begin
        side_q <= cfg_grid_side_i;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    i_d       = i_q;
    j_d       = j_q;
    rd_zero_d = rd_zero_q;
    ctl_o     = '0;
    ctl_o.kind    = kind_q;
    ctl_o.row     = tgt_row;
    ctl_o.col     = tgt_col;
    ctl_o.rd_zero = rd_zero_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (cmd)
            CMD_WRITE_CELL: begin
              ctl_o.wr_cell = in_range;
            end
            CMD_WRITE_HALO: begin
              ctl_o.wr_halo = CFG_W'(col_i) < SIDE_MAX;
            end
            CMD_SWEEP: begin
              kind_d  = VIS_TL;
              i_d     = SIDE_W'(1);
              j_d     = SIDE_W'(1);
              state_d = ST_SW_RD0;
            end
            CMD_READ_CELL: begin
              ctl_o.rd_cell = 1'b1;
              rd_zero_d     = !in_range;
              state_d       = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        ctl_o.rd_capture = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_SW_RD0: begin
        state_d = ST_SW_RD1;
      end
      ST_SW_RD1: begin
        ctl_o.sw_rd1 = 1'b1;
        state_d      = ST_SW_WR;
      end
      ST_SW_WR: begin
        ctl_o.sw_wr = 1'b1;
        state_d     = ST_SW_RD0;
        case (kind_q)
          VIS_TL: kind_d = VIS_TR;
          VIS_TR: kind_d = VIS_BL;
          VIS_BL: kind_d = VIS_BR;
          VIS_BR: begin
            if (last == SIDE_W'(1)) begin
              state_d = ST_IDLE;
            end else begin
              kind_d = VIS_TOP;
              i_d    = SIDE_W'(1);
            end
          end
          VIS_TOP:  kind_d = VIS_BOT;
          VIS_BOT:  kind_d = VIS_LEFT;
          VIS_LEFT: kind_d = VIS_RIGHT;
          VIS_RIGHT: begin
            if (i_q == last_m1) begin
              kind_d = VIS_INNER;
              i_d    = SIDE_W'(1);
              j_d    = SIDE_W'(1);
            end else begin
              kind_d = VIS_TOP;
              i_d    = i_q + SIDE_W'(1);
            end
          end
          VIS_INNER: begin
            if (j_q == last_m1) begin
              if (i_q == last_m1) begin
                state_d = ST_IDLE;
              end else begin
                i_d = i_q + SIDE_W'(1);
                j_d = SIDE_W'(1);
              end
            end else begin
              j_d = j_q + SIDE_W'(1);
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

[hw/rtl/grs_datapath.sv]
// ----------------------------------------------------------------------------
// grs_datapath
// Datapath: tile and halo memories, neighbor addressing, four-way average.
// ----------------------------------------------------------------------------
`default_nettype none

module grs_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire grs_pkg::ctl_t                     ctl_i,
  input  wire logic [grs_pkg::COORD_W-1:0]       row_i,
  input  wire logic [grs_pkg::COORD_W-1:0]       col_i,
  input  wire logic [grs_pkg::HSIDE_W-1:0]       halo_side_i,
  input  wire logic signed [grs_pkg::DATA_W-1:0] value_i,
  output logic                                   read_valid_o,
  output logic signed [grs_pkg::DATA_W-1:0]      read_value_o
);

  import grs_pkg::*;

  logic [SIDE_W-1:0]  r, c, r_up, r_dn, c_lf, c_rt;
  logic [TILE_AW-1:0] a_up, a_dn, a_lf, a_rt, a_host, a_self;
  logic [TILE_AW-1:0] ra0, rb0, ra1;
  logic [TILE_AW-1:0] tile_ra, tile_rb, tile_wa;
  logic               tile_we;
  cell_t              tile_wd;
  cell_t              tile_a, tile_b;

  halo_e              h_side_a, h_side_b;
  logic [SIDE_W-1:0]  h_idx_a;
  logic [HALO_AW-1:0] halo_ra, halo_rb, halo_wa;
  cell_t              halo_a, halo_b;

  cell_t              a0_q, b0_q;
  cell_t              opx, opy;
  logic               is_corner, is_edge;
  logic [SUM_W-1:0]   sum;
  cell_t              relaxed;

  logic                    read_valid_q;
  logic [DATA_W-1:0]       read_value_q;

  // neighbor coordinates; out-of-tile ones may address a read, but that data is never used
  assign r    = ctl_i.row;
  assign c    = ctl_i.col;
  assign r_up = r - SIDE_W'(1);
  assign r_dn = r + SIDE_W'(1);
  assign c_lf = c - SIDE_W'(1);
  assign c_rt = c + SIDE_W'(1);

  assign a_up   = {r_up, c};
  assign a_dn   = {r_dn, c};
  assign a_lf   = {r, c_lf};
  assign a_rt   = {r, c_rt};
  assign a_self = {r, c};
  assign a_host = {row_i[SIDE_W-1:0], col_i[SIDE_W-1:0]};

  assign is_corner = ctl_i.kind inside {VIS_TL, VIS_TR, VIS_BL, VIS_BR};
  assign is_edge   = ctl_i.kind inside {VIS_TOP, VIS_BOT, VIS_LEFT, VIS_RIGHT};

  // first read pair, second read on port a
  always_comb begin
    case (ctl_i.kind)
      VIS_TL:            begin ra0 = a_rt; rb0 = a_dn; ra1 = a_lf; end
      VIS_TR:            begin ra0 = a_lf; rb0 = a_dn; ra1 = a_lf; end
      VIS_BL:            begin ra0 = a_rt; rb0 = a_up; ra1 = a_lf; end
      VIS_BR:            begin ra0 = a_lf; rb0 = a_up; ra1 = a_lf; end
      VIS_TOP:           begin ra0 = a_rt; rb0 = a_lf; ra1 = a_dn; end
      VIS_BOT:           begin ra0 = a_rt; rb0 = a_lf; ra1 = a_up; end
      VIS_LEFT:          begin ra0 = a_dn; rb0 = a_up; ra1 = a_rt; end
      VIS_RIGHT:         begin ra0 = a_dn; rb0 = a_up; ra1 = a_lf; end
      VIS_INNER:         begin ra0 = a_dn; rb0 = a_up; ra1 = a_lf; end
      default:           begin ra0 = a_dn; rb0 = a_up; ra1 = a_lf; end
    endcase
  end

  // halo selection: port a for the up/down corner halo and the edge halo,
  // port b for the left/right corner halo
  always_comb begin
    case (ctl_i.kind)
      VIS_TL, VIS_TR, VIS_TOP: begin h_side_a = HALO_UP;    h_idx_a = c; end
      VIS_BL, VIS_BR, VIS_BOT: begin h_side_a = HALO_DOWN;  h_idx_a = c; end
      VIS_LEFT:                begin h_side_a = HALO_LEFT;  h_idx_a = r; end
      VIS_RIGHT:               begin h_side_a = HALO_RIGHT; h_idx_a = r; end
      default:                 begin h_side_a = HALO_UP;    h_idx_a = c; end
    endcase
  end

  assign h_side_b = (ctl_i.kind inside {VIS_TL, VIS_BL}) ? HALO_LEFT : HALO_RIGHT;

  assign halo_ra = {h_side_a, h_idx_a};
  assign halo_rb = {h_side_b, r};
  assign halo_wa = {halo_side_i, col_i[SIDE_W-1:0]};

  assign tile_ra = ctl_i.rd_cell ? a_host : (ctl_i.sw_rd1 ? ra1 : ra0);
  assign tile_rb = ctl_i.sw_rd1 ? a_rt : rb0;

  // capture the first read pair
  always_ff @(posedge clk_i) begin
    if (ctl_i.sw_rd1) begin
      a0_q <= tile_a;
      b0_q <= tile_b;
    end
  end

  // remaining two operands
  assign opx = is_corner ? halo_a : tile_a;
  assign opy = is_corner ? halo_b : (is_edge ? halo_a : tile_b);

  assign sum = {{2{a0_q[VALUE_BITS-1]}}, a0_q} + {{2{b0_q[VALUE_BITS-1]}}, b0_q}
             + {{2{opx[VALUE_BITS-1]}}, opx} + {{2{opy[VALUE_BITS-1]}}, opy};
  // arithmetic shift by two, floor toward minus infinity
  assign relaxed = sum[SUM_W-1:2];

  assign tile_we = ctl_i.wr_cell || ctl_i.sw_wr;
  assign tile_wa = ctl_i.wr_cell ? a_host : a_self;
  assign tile_wd = ctl_i.wr_cell ? wrap_in(value_i) : relaxed;

  grs_ram #(
    .Width (VALUE_BITS),
    .Depth (TILE_DEPTH)
  ) u_tile_ram (
    .clk_i     (clk_i),
    .we_i      (tile_we),
    .waddr_i   (tile_wa),
    .wdata_i   (tile_wd),
    .raddr_a_i (tile_ra),
    .raddr_b_i (tile_rb),
    .rdata_a_o (tile_a),
    .rdata_b_o (tile_b)
  );

  grs_ram #(
    .Width (VALUE_BITS),
    .Depth (HALO_DEPTH)
  ) u_halo_ram (
    .clk_i     (clk_i),
    .we_i      (ctl_i.wr_halo),
    .waddr_i   (halo_wa),
    .wdata_i   (wrap_in(value_i)),
    .raddr_a_i (halo_ra),
    .raddr_b_i (halo_rb),
    .rdata_a_o (halo_a),
    .rdata_b_o (halo_b)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_valid_q <= 1'b0;
    end else begin
      read_valid_q <= ctl_i.rd_capture;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_capture) begin
      read_value_q <= ctl_i.rd_zero ? '0 : cell_out(tile_a);
    end
  end

  assign read_valid_o = read_valid_q;
  assign read_value_o = read_value_q;

endmodule

`default_nettype wire

[hw/rtl/grid_relaxation_sweep.sv]
// ----------------------------------------------------------------------------
// grid_relaxation_sweep
// Square tile of fixed-point cells with four halo rows, relaxed in place by a
// five-point Gauss-Seidel sweep; host writes cells and halos, reads cells.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ---------------------------
//  command   in         start_i high, busy_o low  command_i, halo_side_i,
//                                                  row_i, col_i, value_i
//  result    out        read_valid_o, one cycle   read_value_o
//  config    in         cfg_valid_i & cfg_ready_o cfg_grid_side_i
//
//  cell write and halo write: done at the accepting edge
//  cell read: busy for one cycle, result strobed in the cycle after that
//  sweep: busy while each cell steps through ST_SW_RD0, ST_SW_RD1 and ST_SW_WR,
//    set by the tile memory's two read ports (two read states and one write state per cell)
//  reset clears control and sets the side to 64; the stores are not cleared
//  results cannot be stalled: read_valid_o lasts exactly one cycle
//
`default_nettype none

module grid_relaxation_sweep (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // command transaction
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [grs_pkg::CMD_W-1:0]         command_i,
  input  wire logic [grs_pkg::HSIDE_W-1:0]       halo_side_i,
  input  wire logic [grs_pkg::COORD_W-1:0]       row_i,
  input  wire logic [grs_pkg::COORD_W-1:0]       col_i,
  input  wire logic signed [grs_pkg::DATA_W-1:0] value_i,
  // result
  output logic                                   read_valid_o,
  output logic signed [grs_pkg::DATA_W-1:0]      read_value_o,
  // grid side register
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [grs_pkg::CFG_W-1:0]         cfg_grid_side_i
);

  import grs_pkg::*;

  // commands from the sequencer to the datapath
  ctl_t ctl;

  // controller: decodes transactions, holds the side, walks the sweep
  // order (corners, interleaved edges, interior row-major)
  grs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .command_i       (command_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_grid_side_i (cfg_grid_side_i),
    .cfg_ready_o     (cfg_ready_o),
    .busy_o          (busy_o),
    .ctl_o           (ctl)
  );

  // datapath: tile and halo memories, neighbor address muxing, the
  // four-operand sum with floor shift, and the read result register
  grs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .row_i        (row_i),
    .col_i        (col_i),
    .halo_side_i  (halo_side_i),
    .value_i      (value_i),
    .read_valid_o (read_valid_o),
    .read_value_o (read_value_o)
  );

endmodule

`default_nettype wire
